/* rtl/rwmm_pkg.sv */
// shared types, sizes and the controller to datapath command struct
// for the rtt window median monitor; no dependencies
package rwmm_pkg;

    localparam int WINDOW = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int N_LINK = 3;
    localparam int HELD_W = 5;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [FILL_W-1:0] t_fill;

    typedef struct packed {
        logic  wr_en;
        t_idx  wr_addr;
        t_idx  rd_addr;
        logic  cand_load;
        logic  cnt_en;
        logic  judge;
        t_fill rank;
    } t_cmd;

endpackage

/* rtl/rwmm_ctrl.sv */
// sequencer for the rank search: write cursor, fill count, candidate and scan indexes
// depends on rwmm_pkg
module rwmm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output rwmm_pkg::t_cmd o_cmd,
    output rwmm_pkg::t_fill o_fill
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CAND,
        S_SCAN,
        S_JUDGE,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    rwmm_pkg::t_idx  r_slot, n_slot;
    rwmm_pkg::t_fill r_fill, n_fill;
    rwmm_pkg::t_idx  r_i, n_i;
    rwmm_pkg::t_idx  r_j, n_j;

    logic last_i;
    logic last_j;

    assign last_i = (rwmm_pkg::FILL_W'(r_i) == r_fill - rwmm_pkg::FILL_W'(1));
    assign last_j = (rwmm_pkg::FILL_W'(r_j) == r_fill - rwmm_pkg::FILL_W'(1));

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_fill  = r_fill;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd           = '0;
        o_cmd.wr_addr   = r_slot;
        o_cmd.rank      = r_fill >> 1;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.wr_en = 1'b1;
                    n_slot = (r_slot == rwmm_pkg::IDX_W'(rwmm_pkg::WINDOW - 1)) ? '0
                           : r_slot + rwmm_pkg::IDX_W'(1);
                    if (r_fill != rwmm_pkg::FILL_W'(rwmm_pkg::WINDOW)) begin
                        n_fill = r_fill + rwmm_pkg::FILL_W'(1);
                    end
                    n_i = '0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.rd_addr = r_i;
                n_state = S_CAND;
            end
            S_CAND: begin
                o_cmd.cand_load = 1'b1;
                o_cmd.rd_addr   = '0;
                n_j = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.cnt_en  = 1'b1;
                o_cmd.rd_addr = r_j + rwmm_pkg::IDX_W'(1);
                if (last_j) begin
                    n_state = S_JUDGE;
                end else begin
                    n_j = r_j + rwmm_pkg::IDX_W'(1);
                end
            end
            S_JUDGE: begin
                o_cmd.judge   = 1'b1;
                o_cmd.rd_addr = r_i + rwmm_pkg::IDX_W'(1);
                if (last_i) begin
                    n_state = S_OUT;
                end else begin
                    n_i = r_i + rwmm_pkg::IDX_W'(1);
                    n_state = S_CAND;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_fill  <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_fill  <= n_fill;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_fill  = r_fill;

endmodule

/* rtl/rwmm_datapath.sv */
// three sample rings, candidate registers, rank counters and median registers
// depends on rwmm_pkg; driven by rwmm_ctrl commands
module rwmm_datapath (
    input  logic            i_clk,
    input  rwmm_pkg::t_cmd  i_cmd,
    input  rwmm_pkg::t_word i_rtt_ab,
    input  rwmm_pkg::t_word i_rtt_bc,
    input  rwmm_pkg::t_word i_rtt_ac,
    output rwmm_pkg::t_word o_median_ab,
    output rwmm_pkg::t_word o_median_bc,
    output rwmm_pkg::t_word o_median_ac
);

    rwmm_pkg::t_word r_mem   [rwmm_pkg::N_LINK][rwmm_pkg::WINDOW];
    rwmm_pkg::t_word r_rdata [rwmm_pkg::N_LINK];
    rwmm_pkg::t_word r_cand  [rwmm_pkg::N_LINK];
    rwmm_pkg::t_word r_med   [rwmm_pkg::N_LINK];
    rwmm_pkg::t_fill r_lt    [rwmm_pkg::N_LINK];
    rwmm_pkg::t_fill r_le    [rwmm_pkg::N_LINK];
    rwmm_pkg::t_word wdata   [rwmm_pkg::N_LINK];

    assign wdata[0] = i_rtt_ab;
    assign wdata[1] = i_rtt_bc;
    assign wdata[2] = i_rtt_ac;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < rwmm_pkg::N_LINK; r++) begin
            if (i_cmd.wr_en) begin
                r_mem[r][i_cmd.wr_addr] <= wdata[r];
            end
            r_rdata[r] <= r_mem[r][i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < rwmm_pkg::N_LINK; r++) begin
            if (i_cmd.cand_load) begin
                r_cand[r] <= r_rdata[r];
                r_lt[r]   <= '0;
                r_le[r]   <= '0;
            end else if (i_cmd.cnt_en) begin
                if (r_rdata[r] < r_cand[r]) begin
                    r_lt[r] <= r_lt[r] + rwmm_pkg::FILL_W'(1);
                end
                if (r_rdata[r] <= r_cand[r]) begin
                    r_le[r] <= r_le[r] + rwmm_pkg::FILL_W'(1);
                end
            end
            // candidate sits at the wanted rank
            if (i_cmd.judge && (r_lt[r] <= i_cmd.rank) && (r_le[r] > i_cmd.rank)) begin
                r_med[r] <= r_cand[r];
            end
        end
    end

    assign o_median_ab = r_med[0];
    assign o_median_bc = r_med[1];
    assign o_median_ac = r_med[2];

endmodule

/* rtl/rtt_window_median_monitor.sv */
// o_valid rises once the rank search has run over all n samples held after the push;
// the rank search scans every held entry once per candidate
// a new input beat is accepted only after the previous result has been delivered
// reset: synchronous active low; clears write cursor, fill count and sequencer,
// ring contents stay undefined and only entries already written are used
module rtt_window_median_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_rtt_ab,
    input  logic [31:0] i_rtt_bc,
    input  logic [31:0] i_rtt_ac,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_median_ab,
    output logic [31:0] o_median_bc,
    output logic [31:0] o_median_ac,
    output logic        o_triangle_ok,
    output logic [4:0]  o_samples_held
);

    rwmm_pkg::t_cmd  cmd;
    rwmm_pkg::t_fill fill;

    rwmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .o_fill  (fill)
    );

    rwmm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_rtt_ab    (i_rtt_ab),
        .i_rtt_bc    (i_rtt_bc),
        .i_rtt_ac    (i_rtt_ac),
        .o_median_ab (o_median_ab),
        .o_median_bc (o_median_bc),
        .o_median_ac (o_median_ac)
    );

    assign o_triangle_ok  = ({1'b0, o_median_ab} + {1'b0, o_median_bc}) >= {1'b0, o_median_ac};
    assign o_samples_held = rwmm_pkg::HELD_W'(fill);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready did not drop after an accepted beat");

    a_ready_after_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_ready)
        else $error("ready did not return after a delivered beat");
`endif

endmodule
